// ----- hdl/height_difference_colormap_top_defines.svh -----
// assertion macros for the height difference colormap block
// used by the top level, expects clock and reset in scope
`ifndef HEIGHT_DIFFERENCE_COLORMAP_TOP_DEFINES_SVH
`define HEIGHT_DIFFERENCE_COLORMAP_TOP_DEFINES_SVH

// condition implies expression in the same cycle
`define HDC_ASSERT_NOW(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("hdc assertion failed");

// condition implies expression in the next cycle
`define HDC_ASSERT_NEXT(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("hdc assertion failed");

`endif

// ----- hdl/hdc_pkg.sv -----
// shared widths, types, register codes and the ramp color table
// no dependencies
`timescale 1ns / 1ps

package hdc_pkg;

   // field widths
   localparam int HEIGHT_W    = 24;
   localparam int DIFF_W      = HEIGHT_W + 1;
   localparam int SCALE_W     = 36;
   localparam int RGBA_W      = 32;
   localparam int CH_W        = 8;
   localparam int NUM_CH      = 3;

   // ramp position arithmetic
   localparam int MAG_W       = DIFF_W;
   localparam int SCALE_SPLIT = 18;
   localparam int SCALE_HI_W  = SCALE_W - SCALE_SPLIT;
   localparam int PART_LO_W   = MAG_W + SCALE_SPLIT;
   localparam int PART_HI_W   = MAG_W + SCALE_HI_W;
   localparam int PROD_W      = MAG_W + SCALE_W;
   localparam int FRAC_W      = 16;
   localparam int POS_W       = PROD_W - FRAC_W;
   localparam int IDX_W       = 3;
   localparam int STEP_W      = CH_W + 2;

   localparam logic [IDX_W-1:0]        RAMP_TOP = 3'd5;
   localparam logic [IDX_W+FRAC_W-1:0] POS_MAX  = {RAMP_TOP, {FRAC_W{1'b0}}};
   localparam logic [CH_W-1:0]         ALPHA_OPAQUE = 8'hFF;

   // apb port
   localparam int APB_DATA_W  = 64;
   localparam int APB_ADDR_W  = 5;
   localparam int REG_SEL_LSB = 3;
   localparam int REG_SEL_W   = APB_ADDR_W - REG_SEL_LSB;

   typedef enum logic [REG_SEL_W-1:0] {
      REG_RANGE_LOW  = 2'd0,
      REG_RAMP_SCALE = 2'd1,
      REG_BACKGROUND = 2'd2
   } csr_index_type;

   // register reset values
   localparam logic [DIFF_W-1:0]  RANGE_LOW_RST  = '0;
   localparam logic [SCALE_W-1:0] RAMP_SCALE_RST = 36'd65536;
   localparam logic [RGBA_W-1:0]  BACKGROUND_RST = '0;

   // configuration seen by the datapath
   typedef struct packed {
      logic [DIFF_W-1:0]  range_low;
      logic [SCALE_W-1:0] ramp_scale;
      logic [RGBA_W-1:0]  background;
   } cfg_type;

   // ramp position handed from the position stages to the blend stages
   typedef struct packed {
      logic              valid;
      logic              pixel_valid;
      logic [DIFF_W-1:0] diff;
      logic [IDX_W-1:0]  lo;
      logic [FRAC_W-1:0] frac;
   } pos_type;

   // lane 0 red, lane 1 green, lane 2 blue
   typedef logic [NUM_CH-1:0][CH_W-1:0] color_type;

   // six fixed ramp colors
   function automatic color_type ramp_color(input logic [IDX_W-1:0] idx);
      color_type c;
      unique case (idx)
         3'd0:    c = {8'd255, 8'd102, 8'd153};
         3'd1:    c = {8'd255, 8'd0,   8'd0};
         3'd2:    c = {8'd0,   8'd255, 8'd0};
         3'd3:    c = {8'd0,   8'd255, 8'd255};
         3'd4:    c = {8'd0,   8'd102, 8'd255};
         3'd5:    c = {8'd0,   8'd0,   8'd255};
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/hdc_req_if.sv -----
// request channel: surface and terrain heights plus pixel valid flag
// depends on hdc_pkg
`timescale 1ns / 1ps

interface hdc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [hdc_pkg::HEIGHT_W-1:0] surface_height;
   logic signed [hdc_pkg::HEIGHT_W-1:0] terrain_height;
   logic                                pixel_valid;

   modport source (output valid, surface_height, terrain_height, pixel_valid,
                   input ready);
   modport sink   (input valid, surface_height, terrain_height, pixel_valid,
                   output ready);
endinterface

// ----- hdl/hdc_rsp_if.sv -----
// response channel: height difference and rgba color
// depends on hdc_pkg
`timescale 1ns / 1ps

interface hdc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [hdc_pkg::DIFF_W-1:0] height_diff;
   logic [hdc_pkg::CH_W-1:0]          red;
   logic [hdc_pkg::CH_W-1:0]          green;
   logic [hdc_pkg::CH_W-1:0]          blue;
   logic [hdc_pkg::CH_W-1:0]          alpha;

   modport source (output valid, height_diff, red, green, blue, alpha, input ready);
   modport sink   (input valid, height_diff, red, green, blue, alpha, output ready);
endinterface

// ----- hdl/hdc_csr.sv -----
// apb register file: range_low, ramp_scale, background_rgba
// depends on hdc_pkg
`timescale 1ns / 1ps

module hdc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hdc_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [hdc_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [hdc_pkg::APB_DATA_W-1:0]  prdata,
   output logic                            pready,
   output hdc_pkg::cfg_type                cfg
);

   logic [hdc_pkg::DIFF_W-1:0]  range_low_ff;
   logic [hdc_pkg::SCALE_W-1:0] ramp_scale_ff;
   logic [hdc_pkg::RGBA_W-1:0]  background_ff;
   logic                        wr_en;
   hdc_pkg::csr_index_type      reg_sel;

   // register select from the 8-byte aligned address
   assign reg_sel = hdc_pkg::csr_index_type'(paddr[hdc_pkg::APB_ADDR_W-1:hdc_pkg::REG_SEL_LSB]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= hdc_pkg::RANGE_LOW_RST;
         ramp_scale_ff <= hdc_pkg::RAMP_SCALE_RST;
         background_ff <= hdc_pkg::BACKGROUND_RST;
      end else if (wr_en) begin
         unique case (reg_sel)
            hdc_pkg::REG_RANGE_LOW:  range_low_ff  <= pwdata[hdc_pkg::DIFF_W-1:0];
            hdc_pkg::REG_RAMP_SCALE: ramp_scale_ff <= pwdata[hdc_pkg::SCALE_W-1:0];
            hdc_pkg::REG_BACKGROUND: background_ff <= pwdata[hdc_pkg::RGBA_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         hdc_pkg::REG_RANGE_LOW:
            prdata = {{(hdc_pkg::APB_DATA_W-hdc_pkg::DIFF_W){1'b0}}, range_low_ff};
         hdc_pkg::REG_RAMP_SCALE:
            prdata = {{(hdc_pkg::APB_DATA_W-hdc_pkg::SCALE_W){1'b0}}, ramp_scale_ff};
         hdc_pkg::REG_BACKGROUND:
            prdata = {{(hdc_pkg::APB_DATA_W-hdc_pkg::RGBA_W){1'b0}}, background_ff};
         default:
            prdata = '0;
      endcase
   end

   assign cfg.range_low  = range_low_ff;
   assign cfg.ramp_scale = ramp_scale_ff;
   assign cfg.background = background_ff;

endmodule

// ----- hdl/hdc_ramp_pos.sv -----
// three pipeline stages: height difference, split scale multiply,
// partial product sum with clamp to the ramp top; depends on hdc_pkg, hdc_req_if
`timescale 1ns / 1ps

module hdc_ramp_pos (
   input  logic             clock,
   input  logic             reset,
   hdc_req_if.sink          req_chan,
   input  hdc_pkg::cfg_type cfg,
   output hdc_pkg::pos_type pos_out,
   input  logic             pos_ready
);

   // stage 1 registers
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_pix_ff;
   logic [hdc_pkg::DIFF_W-1:0]     s1_diff_ff, s1_diff_in;
   logic [hdc_pkg::MAG_W-1:0]      s1_mag_ff, s1_mag_in;
   // stage 2 registers
   logic                           s2_valid_ff;
   logic                           s2_pix_ff;
   logic [hdc_pkg::DIFF_W-1:0]     s2_diff_ff;
   logic [hdc_pkg::PART_LO_W-1:0]  s2_plo_ff, s2_plo_in;
   logic [hdc_pkg::PART_HI_W-1:0]  s2_phi_ff, s2_phi_in;
   // stage 3 register
   hdc_pkg::pos_type               pos_ff, pos_in;

   logic                           en1, en2, en3;
   logic [hdc_pkg::DIFF_W:0]       rel;
   logic [hdc_pkg::PROD_W-1:0]     prod;
   logic [hdc_pkg::POS_W-1:0]      pos_full;
   logic                           over_top;

   // stall chain, a stage loads when empty or when it moves on
   assign en3 = !pos_ff.valid || pos_ready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_chan.ready = en1;

   // stage 1: difference and distance above range_low, negatives to zero
   always_comb begin
      s1_valid_in = req_chan.valid;
      s1_diff_in  = {req_chan.surface_height[hdc_pkg::HEIGHT_W-1], req_chan.surface_height}
                  - {req_chan.terrain_height[hdc_pkg::HEIGHT_W-1], req_chan.terrain_height};
      rel         = {s1_diff_in[hdc_pkg::DIFF_W-1], s1_diff_in}
                  - {cfg.range_low[hdc_pkg::DIFF_W-1], cfg.range_low};
      if (!rel[hdc_pkg::DIFF_W] && (rel != '0)) begin
         s1_mag_in = rel[hdc_pkg::MAG_W-1:0];
      end else begin
         s1_mag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_pix_ff  <= req_chan.pixel_valid;
         s1_diff_ff <= s1_diff_in;
         s1_mag_ff  <= s1_mag_in;
      end
   end

   // stage 2: scale split into two 18-bit halves
   assign s2_plo_in = hdc_pkg::PART_LO_W'(s1_mag_ff)
                    * hdc_pkg::PART_LO_W'(cfg.ramp_scale[hdc_pkg::SCALE_SPLIT-1:0]);
   assign s2_phi_in = hdc_pkg::PART_HI_W'(s1_mag_ff)
                    * hdc_pkg::PART_HI_W'(cfg.ramp_scale[hdc_pkg::SCALE_W-1:hdc_pkg::SCALE_SPLIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_pix_ff  <= s1_pix_ff;
         s2_diff_ff <= s1_diff_ff;
         s2_plo_ff  <= s2_plo_in;
         s2_phi_ff  <= s2_phi_in;
      end
   end

   // stage 3: full product, drop 16 bits, clamp at the last color
   always_comb begin
      prod     = {s2_phi_ff, {hdc_pkg::SCALE_SPLIT{1'b0}}}
               + hdc_pkg::PROD_W'(s2_plo_ff);
      pos_full = prod[hdc_pkg::PROD_W-1:hdc_pkg::FRAC_W];
      over_top = (pos_full[hdc_pkg::POS_W-1:hdc_pkg::IDX_W+hdc_pkg::FRAC_W] != '0)
              || (pos_full[hdc_pkg::IDX_W+hdc_pkg::FRAC_W-1:0] > hdc_pkg::POS_MAX);
      pos_in.valid       = s2_valid_ff;
      pos_in.pixel_valid = s2_pix_ff;
      pos_in.diff        = s2_diff_ff;
      if (over_top) begin
         pos_in.lo   = hdc_pkg::RAMP_TOP;
         pos_in.frac = '0;
      end else begin
         pos_in.lo   = pos_full[hdc_pkg::IDX_W+hdc_pkg::FRAC_W-1:hdc_pkg::FRAC_W];
         pos_in.frac = pos_full[hdc_pkg::FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff.valid <= 1'b0;
      end else if (en3) begin
         pos_ff.valid <= pos_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         pos_ff.pixel_valid <= pos_in.pixel_valid;
         pos_ff.diff        <= pos_in.diff;
         pos_ff.lo          <= pos_in.lo;
         pos_ff.frac        <= pos_in.frac;
      end
   end

   assign pos_out = pos_ff;

endmodule

// ----- hdl/hdc_blend.sv -----
// two pipeline stages: per-channel interpolation step multiply, then
// add to the base color, background select and output register; depends on hdc_pkg, hdc_rsp_if
`timescale 1ns / 1ps

module hdc_blend (
   input  logic             clock,
   input  logic             reset,
   input  hdc_pkg::pos_type pos_in,
   output logic             pos_ready,
   input  hdc_pkg::cfg_type cfg,
   hdc_rsp_if.source        rsp_chan
);

   // stage 4 registers
   logic                              s4_valid_ff;
   logic                              s4_pix_ff;
   logic [hdc_pkg::DIFF_W-1:0]        s4_diff_ff;
   hdc_pkg::color_type                s4_base_ff, base_c;
   logic signed [hdc_pkg::STEP_W-1:0] s4_step_ff [hdc_pkg::NUM_CH];
   logic signed [hdc_pkg::STEP_W-1:0] step_in [hdc_pkg::NUM_CH];
   // output registers
   logic                              rsp_valid_ff;
   logic [hdc_pkg::DIFF_W-1:0]        rsp_diff_ff;
   logic [3:0][hdc_pkg::CH_W-1:0]     rsp_rgba_ff, rsp_rgba_in;

   logic                              en4, en_out;
   logic [hdc_pkg::IDX_W-1:0]         hi_idx;
   hdc_pkg::color_type                top_c;
   hdc_pkg::color_type                mix_c;

   assign en_out    = !rsp_valid_ff || rsp_chan.ready;
   assign en4       = !s4_valid_ff || en_out;
   assign pos_ready = en4;

   // stage 4: neighbor colors and floor((hi - lo) * frac / 2^16) per channel
   always_comb begin
      logic signed [hdc_pkg::CH_W:0]              delta;
      logic signed [hdc_pkg::FRAC_W:0]            frac_s;
      logic signed [hdc_pkg::CH_W+hdc_pkg::FRAC_W+1:0] prod;
      hi_idx = (pos_in.lo < hdc_pkg::RAMP_TOP) ? pos_in.lo + 3'd1 : hdc_pkg::RAMP_TOP;
      base_c = hdc_pkg::ramp_color(pos_in.lo);
      top_c  = hdc_pkg::ramp_color(hi_idx);
      frac_s = $signed({1'b0, pos_in.frac});
      for (int k = 0; k < hdc_pkg::NUM_CH; k++) begin
         delta      = $signed({1'b0, top_c[k]}) - $signed({1'b0, base_c[k]});
         prod       = delta * frac_s;
         step_in[k] = prod[hdc_pkg::CH_W+hdc_pkg::FRAC_W+1:hdc_pkg::FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= pos_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_pix_ff  <= pos_in.pixel_valid;
         s4_diff_ff <= pos_in.diff;
         s4_base_ff <= base_c;
         s4_step_ff <= step_in;
      end
   end

   // output stage: base plus step, or the background color
   always_comb begin
      logic signed [hdc_pkg::STEP_W-1:0] sum;
      for (int k = 0; k < hdc_pkg::NUM_CH; k++) begin
         sum      = $signed({2'b00, s4_base_ff[k]}) + s4_step_ff[k];
         mix_c[k] = sum[hdc_pkg::CH_W-1:0];
      end
      if (s4_pix_ff) begin
         rsp_rgba_in = {hdc_pkg::ALPHA_OPAQUE, mix_c};
      end else begin
         rsp_rgba_in = cfg.background;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_diff_ff <= s4_diff_ff;
         rsp_rgba_ff <= rsp_rgba_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.height_diff = rsp_diff_ff;
   assign rsp_chan.red         = rsp_rgba_ff[0];
   assign rsp_chan.green       = rsp_rgba_ff[1];
   assign rsp_chan.blue        = rsp_rgba_ff[2];
   assign rsp_chan.alpha       = rsp_rgba_ff[3];

endmodule

// ----- hdl/height_difference_colormap_top.sv -----
// Height difference colormap: each request carries a surface and a terrain height
// (signed Q16.8) and a valid flag; each response returns the difference and an RGBA
// color, interpolated along a six-color ramp set by range_low and ramp_scale, or the
// background color for invalid pixels. One request is accepted every clock cycle while
// the pipeline is not stalled. A request passes through five register stages to its
// response: difference, the 25x36 scale multiply split into two 25x18 partial products,
// partial product sum with clamp, per-channel interpolation multiply, and the output
// register. A stalled response only holds back the stages behind it until a bubble is
// filled. Registers are written over APB at byte addresses 0, 8 and 16 and should only
// be changed while no requests are in flight.
// depends on hdc_pkg, hdc_req_if, hdc_rsp_if, hdc_csr, hdc_ramp_pos, hdc_blend
`timescale 1ns / 1ps
`include "height_difference_colormap_top_defines.svh"

module height_difference_colormap_top (
   input  logic                            clock,
   input  logic                            reset,
   hdc_req_if.sink                         req_chan,
   hdc_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hdc_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [hdc_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [hdc_pkg::APB_DATA_W-1:0]  prdata,
   output logic                            pready
);

   hdc_pkg::cfg_type cfg;
   hdc_pkg::pos_type pos_link;
   logic             pos_ready;
   logic [2:0]       occupancy_ff, occupancy_in;

   // register file
   hdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ramp position stages
   hdc_ramp_pos u_ramp_pos (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg),
      .pos_out   (pos_link),
      .pos_ready (pos_ready)
   );

   // color blend and output stages
   hdc_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .pos_in    (pos_link),
      .pos_ready (pos_ready),
      .cfg       (cfg),
      .rsp_chan  (rsp_chan)
   );

   // requests in flight, for checking
   always_comb begin
      occupancy_in = occupancy_ff;
      if (req_chan.valid && req_chan.ready) begin
         occupancy_in = occupancy_in + 3'd1;
      end
      if (rsp_chan.valid && rsp_chan.ready) begin
         occupancy_in = occupancy_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
      end else begin
         occupancy_ff <= occupancy_in;
      end
   end

   // checks
   `HDC_ASSERT_NOW(a_stall_only_when_blocked, !req_chan.ready, rsp_chan.valid && !rsp_chan.ready)
   `HDC_ASSERT_NOW(a_occupancy_bound, 1'b1, occupancy_ff <= 3'd5)
   `HDC_ASSERT_NOW(a_no_invented_rsp, occupancy_ff == 3'd0, !rsp_chan.valid)
   `HDC_ASSERT_NOW(a_ramp_index_clamped, pos_link.valid, pos_link.lo <= hdc_pkg::RAMP_TOP)
   `HDC_ASSERT_NEXT(a_link_holds, pos_link.valid && !pos_ready, pos_link.valid && $stable(pos_link))

endmodule

// ----- tb/height_difference_colormap_top_tb.sv -----
// testbench for height_difference_colormap_top: random and directed pixels, APB register setup
// predicts the difference and ramp color of each pixel and checks every response in order
// depends on hdc_pkg, hdc_req_if, hdc_rsp_if and the top level
`timescale 1ns / 1ps

module height_difference_colormap_top_tb;
   import hdc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_MAX   = 10;

   // expected response of one pixel
   typedef struct packed {
      logic signed [DIFF_W-1:0] diff;
      logic [CH_W-1:0]          red;
      logic [CH_W-1:0]          green;
      logic [CH_W-1:0]          blue;
      logic [CH_W-1:0]          alpha;
   } pixel_color_type;

   // register copy, color prediction and queue of awaited pixel colors
   class pixel_color_book;
      logic signed [DIFF_W-1:0] range_low  = RANGE_LOW_RST;
      logic [SCALE_W-1:0]       ramp_scale = RAMP_SCALE_RST;
      logic [RGBA_W-1:0]        background = BACKGROUND_RST;
      int                       ramp_rgb [6][3] = '{'{153, 102, 255}, '{0, 0, 255},
                                                    '{0, 255, 0}, '{255, 255, 0},
                                                    '{255, 102, 0}, '{255, 0, 0}};
      pixel_color_type          awaited [$];
      int                       failures;
      int                       checked;

      function pixel_color_type predict_color(logic signed [HEIGHT_W-1:0] s,
                                              logic signed [HEIGHT_W-1:0] t, logic v);
         pixel_color_type c;
         longint          diff, d, pos, lo, hi, f, acc;
         logic [CH_W-1:0] lane [3];
         diff   = longint'(s) - longint'(t);
         c.diff = diff[DIFF_W-1:0];
         if (!v) begin
            {c.alpha, c.blue, c.green, c.red} = background;
            return c;
         end
         // ramp position in q.16, clamped to [0, 5.0]
         d   = diff - longint'(range_low);
         pos = 0;
         if (d > 0) begin
            pos = (d * longint'({28'b0, ramp_scale})) >>> 16;
            if (pos > (64'd5 << 16)) pos = 64'd5 << 16;
         end
         lo = pos >>> 16;
         f  = pos & 64'hFFFF;
         hi = (lo < 5) ? lo + 1 : 5;
         // linear blend between neighboring colors, truncated
         for (int k = 0; k < 3; k++) begin
            acc     = ramp_rgb[lo][k] * 65536 + (ramp_rgb[hi][k] - ramp_rgb[lo][k]) * f;
            lane[k] = acc[23:16];
         end
         c.red   = lane[0];
         c.green = lane[1];
         c.blue  = lane[2];
         c.alpha = ALPHA_OPAQUE;
         return c;
      endfunction

      function void note_request(logic signed [HEIGHT_W-1:0] s,
                                 logic signed [HEIGHT_W-1:0] t, logic v);
         awaited.push_back(predict_color(s, t, v));
      endfunction

      function void check_response(logic signed [DIFF_W-1:0] diff, logic [CH_W-1:0] r,
                                   logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                                   logic [CH_W-1:0] a);
         pixel_color_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("response with no request pending: diff %0d rgba %h %h %h %h",
                        diff, r, g, b, a);
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (want.diff !== diff || want.red !== r || want.green !== g ||
             want.blue !== b || want.alpha !== a) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display({"mismatch at response %0d: expected diff %0d rgba %h %h %h %h, ",
                         "got diff %0d rgba %h %h %h %h"},
                        checked, want.diff, want.red, want.green, want.blue, want.alpha,
                        diff, r, g, b, a);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic pready;

   hdc_req_if req_if ();
   hdc_rsp_if rsp_if ();

   height_difference_colormap_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   pixel_color_book color_sb = new;
   int send_max_gap;
   int recv_max_gap;
   int stall_request;
   int sent_count;
   int settings_count;
   int cycle_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still awaited",
                  cycle_count, color_sb.awaited.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // one register write: setup then access phase, bus left selected
   task automatic write_csr(input csr_index_type idx, input logic [APB_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_RANGE_LOW:  color_sb.range_low  = value[DIFF_W-1:0];
         REG_RAMP_SCALE: color_sb.ramp_scale = value[SCALE_W-1:0];
         REG_BACKGROUND: color_sb.background = value[RGBA_W-1:0];
         default: ;
      endcase
   endtask

   // all three registers, then release the bus
   task automatic write_config(input logic [DIFF_W-1:0] low, input logic [SCALE_W-1:0] scale,
                               input logic [RGBA_W-1:0] bg);
      write_csr(REG_RANGE_LOW, {39'b0, low});
      write_csr(REG_RAMP_SCALE, {28'b0, scale});
      write_csr(REG_BACKGROUND, {32'b0, bg});
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_count++;
   endtask

   // drop valid and wait until every pixel has come back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (color_sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // offer one pixel after a random gap, hold until accepted
   task automatic send_pixel(input logic signed [HEIGHT_W-1:0] s,
                             input logic signed [HEIGHT_W-1:0] t, input logic v);
      int gap;
      gap = $urandom_range(0, send_max_gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.surface_height <= s;
      req_if.terrain_height <= t;
      req_if.pixel_valid    <= v;
      do @(posedge clock); while (!req_if.ready);
      color_sb.note_request(s, t, v);
      sent_count++;
   endtask

   // mostly differences aimed at the current ramp, some fully random fields
   task automatic random_pixel();
      longint span, diff, lo_s, hi_s, s_val;
      logic signed [HEIGHT_W-1:0] s, t;
      logic v;
      if ($urandom_range(0, 3) == 0) begin
         s = HEIGHT_W'($urandom);
         t = HEIGHT_W'($urandom);
         v = 1'($urandom);
      end else begin
         if (color_sb.ramp_scale == 0) span = 64'd1 << 20;
         else span = 64'd21474836480 / longint'({28'b0, color_sb.ramp_scale});
         if (span < 1) span = 1;
         if (span > (64'd1 << 25)) span = 64'd1 << 25;
         diff = longint'(color_sb.range_low) + longint'($urandom_range(0, span + span / 4))
                - span / 8;
         if (diff > 16777215) diff = 16777215;
         if (diff < -16777215) diff = -16777215;
         // surface chosen so that both heights stay in range
         lo_s  = (diff - 8388608 > -8388608) ? diff - 8388608 : -8388608;
         hi_s  = (diff + 8388607 < 8388607) ? diff + 8388607 : 8388607;
         s_val = lo_s + longint'($urandom_range(0, hi_s - lo_s));
         s     = HEIGHT_W'(s_val);
         t     = HEIGHT_W'(s_val - diff);
         v     = ($urandom_range(0, 7) != 0);
      end
      send_pixel(s, t, v);
   endtask

   // one register setting with its own idling pattern
   task automatic run_phase(input logic [DIFF_W-1:0] low, input logic [SCALE_W-1:0] scale,
                            input logic [RGBA_W-1:0] bg, input int count, input int s_gap,
                            input int r_gap, input int hold);
      wait_idle();
      write_config(low, scale, bg);
      send_max_gap  = s_gap;
      recv_max_gap  = r_gap;
      stall_request = hold;
      repeat (count) random_pixel();
   endtask

   // random ramp: span drawn over many magnitudes
   task automatic run_random_phase(input int count, input int s_gap, input int r_gap,
                                   input int hold);
      longint span;
      span = $urandom_range(1, 1 << $urandom_range(2, 25));
      run_phase(DIFF_W'($urandom), SCALE_W'(64'd21474836480 / span), $urandom, count,
                s_gap, r_gap, hold);
   endtask

   // response side: random or long hold-off, then check
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_request > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall_request) @(posedge clock);
            stall_request = 0;
         end else begin
            gap = $urandom_range(0, recv_max_gap);
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         color_sb.check_response(rsp_if.height_diff, rsp_if.red, rsp_if.green,
                                 rsp_if.blue, rsp_if.alpha);
      end
   end

   // stimulus
   initial begin
      int failures;
      reset                 <= 1'b1;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      req_if.valid          <= 1'b0;
      req_if.surface_height <= '0;
      req_if.terrain_height <= '0;
      req_if.pixel_valid    <= 1'b0;
      cycle_count           <= 0;
      send_max_gap  = 3;
      recv_max_gap  = 3;
      stall_request = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: unit scale, ramp starts at zero
      send_pixel(24'sd0, 24'sd0, 1'b1);
      send_pixel(24'sd1, 24'sd0, 1'b1);
      send_pixel(24'sd32768, 24'sd0, 1'b1);
      send_pixel(24'sd65536, 24'sd0, 1'b1);
      send_pixel(24'sd327679, 24'sd0, 1'b1);
      send_pixel(24'sd327680, 24'sd0, 1'b1);
      send_pixel(24'sd8388607, -24'sd8388608, 1'b1);
      send_pixel(-24'sd8388608, 24'sd8388607, 1'b1);
      send_pixel(-24'sd1, 24'sd0, 1'b1);
      send_pixel(24'sd8388607, 24'sd8388607, 1'b0);
      send_pixel(-24'sd8388608, -24'sd8388608, 1'b0);
      send_pixel(-24'sd8388608, 24'sd8388607, 1'b0);

      // zero scale pins valid pixels to the first color
      wait_idle();
      write_config('0, '0, 32'hC3A5_5A3C);
      send_pixel(24'sd100000, 24'sd0, 1'b1);
      send_pixel(24'sd8388607, -24'sd8388608, 1'b1);
      send_pixel(24'sd5, 24'sd7, 1'b0);
      send_pixel(24'sd0, 24'sd0, 1'b1);

      // random settings with different flow patterns
      run_random_phase(60, 12, 12, 0);
      run_random_phase(60, 0, 0, 0);
      run_random_phase(60, 0, 3, 200);
      run_phase(25'h1000000, 36'hF_FFFF_FFFF, 32'hFFFF_FFFF, 40, 12, 12, 0);
      run_phase(25'h0FFFFFF, 36'd1, 32'h0, 40, 12, 12, 0);
      run_phase(DIFF_W'($urandom), 36'd0, $urandom, 30, 6, 6, 0);
      repeat (4) run_random_phase(30, 12, 12, 0);
      wait_idle();

      failures = color_sb.failures + color_sb.awaited.size();
      $display("sent %0d pixels under %0d register settings, %0d responses checked",
               sent_count, settings_count, color_sb.checked);
      $display("%0d failures, %0d responses never arrived", color_sb.failures,
               color_sb.awaited.size());
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
